// ===== hw/rtl/tss_pkg.sv =====
// Shared types and constants for the Taylor series sine core.
package tss_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WRAP,
    ST_FOLD,
    ST_BMUL,
    ST_BDIV,
    ST_BCHK,
    ST_TMUL,
    ST_TDIV,
    ST_ACC,
    ST_DONE
  } state_e;

  // Command word from the sequencer to the shared multiply/divide unit.
  typedef struct packed {
    logic mul_go;
    logic div_go;
  } unit_cmd_t;

  // Status word from the shared unit back to the sequencer.
  typedef struct packed {
    logic mul_done;
    logic div_done;
  } unit_sts_t;

  // Bound 0.5*10^-m is 2^FRAC / (2*10^m): divisor for digit count m.
  function automatic logic [41:0] two_pow10(input logic [3:0] m);
    logic [41:0] v;
    v = 42'd2;
    for (int i = 0; i < 12; i++) begin
      if (i < int'(m)) v = v * 42'd10;
    end
    return v;
  endfunction

endpackage

// ===== hw/rtl/tss_unit.sv =====
// Shared arithmetic unit: serial fractional multiplier and restoring divider.
module tss_unit #(
  parameter int unsigned W = 64,
  parameter int unsigned FRAC = 48
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tss_pkg::unit_cmd_t cmd_i,
  input  logic [W-1:0]       opa_i,
  input  logic [W-1:0]       opb_i,
  output tss_pkg::unit_sts_t sts_o,
  output logic [W-1:0]       res_o
);

  localparam int unsigned CW = $clog2(W + 1);

  logic          busy_q, busy_d;
  logic          is_div_q, is_div_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [2*W-1:0] prod_q, prod_d;
  logic [W-1:0]  mcand_q, mcand_d;
  logic [W-1:0]  mplier_q, mplier_d;
  logic [W:0]    rem_q, rem_d;
  logic [W-1:0]  quo_q, quo_d;
  logic [W:0]    trial;
  tss_pkg::unit_sts_t sts_d, sts_q;

  // Multiply: 4 bits of the multiplier a cycle; divide: one quotient bit a cycle.
  always_comb begin
    busy_d   = busy_q;
    is_div_d = is_div_q;
    cnt_d    = cnt_q;
    prod_d   = prod_q;
    mcand_d  = mcand_q;
    mplier_d = mplier_q;
    rem_d    = rem_q;
    quo_d    = quo_q;
    sts_d    = '0;
    trial    = {rem_q[W-1:0], quo_q[W-1]} - {1'b0, mcand_q};
    if (!busy_q) begin
      if (cmd_i.mul_go || cmd_i.div_go) begin
        busy_d   = 1'b1;
        is_div_d = cmd_i.div_go;
        mcand_d  = opb_i;
        mplier_d = opa_i;
        quo_d    = opa_i;
        prod_d   = '0;
        rem_d    = '0;
        cnt_d    = cmd_i.div_go ? CW'(W) : CW'(W / 4);
      end
    end else if (is_div_q) begin
      if (trial[W]) begin
        rem_d = {rem_q[W-1:0], quo_q[W-1]};
        quo_d = {quo_q[W-2:0], 1'b0};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[W-2:0], 1'b1};
      end
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d         = 1'b0;
        sts_d.div_done = 1'b1;
      end
    end else begin
      prod_d = (prod_q >> 4) + ({{W{1'b0}}, mcand_q} * (2*W)'(mplier_q[3:0]) << (W - 4));
      mplier_d = mplier_q >> 4;
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d         = 1'b0;
        sts_d.mul_done = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      is_div_q <= 1'b0;
      cnt_q    <= '0;
      sts_q    <= '0;
    end else begin
      busy_q   <= busy_d;
      is_div_q <= is_div_d;
      cnt_q    <= cnt_d;
      sts_q    <= sts_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q   <= prod_d;
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
    rem_q    <= rem_d;
    quo_q    <= quo_d;
  end

  assign sts_o = sts_q;
  assign res_o = is_div_q ? quo_q : prod_q[FRAC +: W];

  // Never signal both completions together.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(sts_q.mul_done && sts_q.div_done))
    else $error("unit: double completion");
  // A completion is signalled only once the unit is no longer busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sts_q.mul_done || sts_q.div_done) |-> !busy_q)
    else $error("unit: completion while busy");
  // Commands are only issued while idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !(cmd_i.mul_go || cmd_i.div_go))
    else $error("unit: command while busy");

endmodule

// ===== hw/rtl/taylor_series_sine_core.sv =====
// Taylor series sine core: range reduction and series on a shared unit.
// Sequence: the angle passes a wrap state (one step per wrap, at most two),
// a fold state, then per added series term a bound check and the term update;
// each term uses two multiplies and two divides on the shared unit, and at
// most MAX_TERMS terms run. Range errors go from accept straight to the done
// state; zero angles go through wrap and fold to the done state.
// Throughput: one word at a time; busy stays high until the result strobe.
// Reset: asynchronous active low; precision resets to 6, sequencer to idle.
module taylor_series_sine_core #(
  parameter int unsigned FRAC_BITS = 48,
  parameter int unsigned MAX_TERMS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic signed [52:0] angle_i,
  output logic               valid_o,
  output logic signed [49:0] sine_o,
  output logic               range_error_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [3:0]         cfg_data_i
);

  localparam int unsigned W  = 64;
  localparam int unsigned KW = 7;
  localparam int unsigned NW = $clog2(MAX_TERMS + 1);
  localparam logic [63:0] PiQ60 = 64'd3622009729038557688;
  localparam logic signed [W-1:0] One = W'(1) << FRAC_BITS;
  localparam logic signed [W-1:0] Ten = One * 10;
  localparam logic signed [W-1:0] Pi =
    W'((PiQ60 + (64'd1 << (59 - FRAC_BITS))) >> (60 - FRAC_BITS));
  localparam logic signed [W-1:0] HalfPi =
    W'((PiQ60 + (64'd1 << (60 - FRAC_BITS))) >> (61 - FRAC_BITS));
  localparam logic signed [W-1:0] TwoPi = Pi * 2;

  // Stopping bound 0.5*10^-m for m = 1..12, built at elaboration.
  function automatic logic [12*W-1:0] bound_table();
    logic [12*W-1:0] t;
    t = '0;
    for (int i = 0; i < 12; i++) begin
      t[i*W +: W] = W'(One) / W'(tss_pkg::two_pow10(4'(i + 1)));
    end
    return t;
  endfunction

  localparam logic [12*W-1:0] BoundTab = bound_table();

  tss_pkg::state_e state_q, state_d;
  logic [3:0]         prec_q;
  logic signed [W-1:0] x_q, x_d;
  logic [W-1:0]       u_q, u_d;
  logic [W-1:0]       term_q, term_d;
  logic [W-1:0]       tmp_q, tmp_d;
  logic signed [W-1:0] acc_q, acc_d;
  logic [W-1:0]       bound_q;
  logic [KW-1:0]      k_q, k_d;
  logic [NW-1:0]      n_q, n_d;
  logic               neg_q, neg_d, resneg_q, resneg_d;
  logic               valid_q, valid_d, rerr_q, rerr_d;
  logic signed [49:0] sine_q, sine_d;
  tss_pkg::unit_cmd_t cmd;
  tss_pkg::unit_sts_t sts;
  logic [W-1:0]       opa, opb, ures;
  logic [3:0]         m_eff;
  logic signed [W-1:0] res_s;

  // Accept configuration only when idle and no word is being taken.
  assign cfg_ready_o = (state_q == tss_pkg::ST_IDLE) && !start;
  assign busy        = (state_q != tss_pkg::ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) prec_q <= 4'd6;
    else if (cfg_valid_i && cfg_ready_o) prec_q <= cfg_data_i;
  end

  // Clamp the digit count and derive the stopping bound.
  always_comb begin
    m_eff = prec_q;
    if (m_eff == 4'd0) m_eff = 4'd1;
    if (m_eff > 4'd12) m_eff = 4'd12;
  end

  always_ff @(posedge clk_i) begin
    if (state_q == tss_pkg::ST_FOLD)
      bound_q <= BoundTab[W*int'(m_eff - 4'd1) +: W];
  end

  tss_unit #(.W(W), .FRAC(FRAC_BITS)) u_unit (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd),
    .opa_i (opa),
    .opb_i (opb),
    .sts_o (sts),
    .res_o (ures)
  );

  assign res_s = resneg_q ? -acc_q : acc_q;

  // Sequencer: wrap, fold, then one bound check and one term per pass.
  always_comb begin
    state_d  = state_q;
    x_d      = x_q;
    u_d      = u_q;
    term_d   = term_q;
    tmp_d    = tmp_q;
    acc_d    = acc_q;
    k_d      = k_q;
    n_d      = n_q;
    neg_d    = neg_q;
    resneg_d = resneg_q;
    valid_d  = 1'b0;
    rerr_d   = rerr_q;
    sine_d   = sine_q;
    cmd      = '0;
    opa      = term_q;
    opb      = u_q;
    unique case (state_q)
      tss_pkg::ST_IDLE: begin
        if (start) begin
          x_d = W'(angle_i);
          if (W'(angle_i) >= Ten || W'(angle_i) <= -Ten) begin
            rerr_d  = 1'b1;
            sine_d  = '0;
            state_d = tss_pkg::ST_DONE;
          end else begin
            rerr_d  = 1'b0;
            state_d = tss_pkg::ST_WRAP;
          end
        end
      end
      tss_pkg::ST_WRAP: begin
        if (x_q > Pi) x_d = x_q - TwoPi;
        else if (x_q < -Pi) x_d = x_q + TwoPi;
        else state_d = tss_pkg::ST_FOLD;
      end
      tss_pkg::ST_FOLD: begin
        resneg_d = (x_q < 0);
        if (x_q < -HalfPi) u_d = Pi + x_q;
        else if (x_q < 0) u_d = -x_q;
        else if (x_q < HalfPi) u_d = x_q;
        else u_d = Pi - x_q;
        term_d = u_d;
        acc_d  = u_d;
        k_d    = KW'(1);
        n_d    = '0;
        neg_d  = 1'b0;
        if (x_q == 0) begin
          sine_d  = '0;
          state_d = tss_pkg::ST_DONE;
        end else state_d = tss_pkg::ST_BMUL;
      end
      tss_pkg::ST_BMUL: begin
        if (n_q == NW'(MAX_TERMS)) state_d = tss_pkg::ST_ACC;
        else begin
          cmd.mul_go = 1'b1;
          state_d    = tss_pkg::ST_BDIV;
        end
      end
      tss_pkg::ST_BDIV: begin
        if (sts.mul_done) begin
          tmp_d      = ures;
          cmd.div_go = 1'b1;
          opa        = ures;
          opb        = W'(k_q) + W'(1);
          state_d    = tss_pkg::ST_BCHK;
        end
      end
      tss_pkg::ST_BCHK: begin
        if (sts.div_done) begin
          if (ures <= bound_q) state_d = tss_pkg::ST_ACC;
          else begin
            cmd.mul_go = 1'b1;
            opa        = tmp_q;
            neg_d      = !neg_q;
            state_d    = tss_pkg::ST_TMUL;
          end
        end
      end
      tss_pkg::ST_TMUL: begin
        if (sts.mul_done) begin
          cmd.div_go = 1'b1;
          opa        = ures;
          opb        = W'((12'(k_q) + 12'd1) * (12'(k_q) + 12'd2));
          state_d    = tss_pkg::ST_TDIV;
        end
      end
      tss_pkg::ST_TDIV: begin
        if (sts.div_done) begin
          term_d  = ures;
          acc_d   = neg_q ? acc_q - ures : acc_q + ures;
          k_d     = k_q + KW'(2);
          n_d     = n_q + NW'(1);
          state_d = tss_pkg::ST_BMUL;
        end
      end
      tss_pkg::ST_ACC: begin
        if (res_s > One) sine_d = 50'(One);
        else if (res_s < -One) sine_d = 50'(-One);
        else sine_d = 50'(res_s);
        state_d = tss_pkg::ST_DONE;
      end
      tss_pkg::ST_DONE: begin
        valid_d = 1'b1;
        state_d = tss_pkg::ST_IDLE;
      end
      default: state_d = tss_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tss_pkg::ST_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q      <= x_d;
    u_q      <= u_d;
    term_q   <= term_d;
    tmp_q    <= tmp_d;
    acc_q    <= acc_d;
    k_q      <= k_d;
    n_q      <= n_d;
    neg_q    <= neg_d;
    resneg_q <= resneg_d;
    rerr_q   <= rerr_d;
    sine_q   <= sine_d;
  end

  assign valid_o       = valid_q;
  assign sine_o        = sine_q;
  assign range_error_o = rerr_q;

  // A result strobe lasts one cycle and comes back to idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) valid_q |=> !valid_q)
    else $error("core: strobe longer than one cycle");
  // A range error always carries a zero sine.
  assert property (@(posedge clk_i) disable iff (!rst_ni) (valid_q && rerr_q) |-> sine_q == '0)
    else $error("core: range error with nonzero sine");
  // Never take configuration while busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni) busy |-> !cfg_ready_o)
    else $error("core: config while busy");

endmodule
